### rtl/ihq_pkg.sv
// Shared types, codes and default sizes of the indexed max-heap queue.
package ihq_pkg;

	localparam int REQ_BITS    = 2;
	localparam int HANDLE_BITS = 10;
	localparam int KEY_IN_BITS = 32;
	localparam int STAMP_BITS  = 32;
	localparam int STATUS_BITS = 3;
	localparam int COUNT_BITS  = 11;

	localparam int DEF_HEAP_DEPTH   = 1024;
	localparam int DEF_HANDLE_COUNT = 1024;
	localparam int DEF_KEY_BITS     = 32;

	localparam logic [REQ_BITS-1:0] REQ_INSERT  = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_REMOVE  = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_EXTRACT = 2'd2;

	localparam logic [STATUS_BITS-1:0] STS_OK     = 3'd0;
	localparam logic [STATUS_BITS-1:0] STS_FULL   = 3'd1;
	localparam logic [STATUS_BITS-1:0] STS_ABSENT = 3'd2;
	localparam logic [STATUS_BITS-1:0] STS_EMPTY  = 3'd3;
	localparam logic [STATUS_BITS-1:0] STS_DUP    = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_LAST,
		S_DN_L,
		S_DN_R,
		S_DN_C,
		S_UP_RD,
		S_UP_C,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [REQ_BITS-1:0]    req_type;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_IN_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [KEY_IN_BITS-1:0] out_key;
		logic [COUNT_BITS-1:0]  count;
	} rsp_t;

endpackage

### rtl/ihq_if.sv
// Request and response channel interfaces of the heap queue.
interface ihq_req_if import ihq_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ihq_rsp_if import ihq_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/ihq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihq_ram import ihq_pkg::*; #(
	parameter int WIDTH = DEF_KEY_BITS,
	parameter int DEPTH = DEF_HEAP_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/indexed_max_heap_queue.sv
// Indexed binary max-heap priority queue, top level.
//
// Requests arrive on req (insert a handle with a key, remove a handle, or
// extract the entry with the largest key); each request gives exactly one
// response on rsp with status, extracted handle and key, and the count held.
// Heap slots live in one RAM of key, stamp and handle; a second RAM maps each
// handle to its slot. One request is worked on at a time by a sequencer that
// reads, compares and writes one heap level per step.
// Rejected requests and removal of the last slot need no heap walk; insert
// climbs level by level, and extract and remove sink level by level, or
// climb instead when a removed slot's entry moves up. Request time is set
// by the single read port of the heap RAM and its registered read data.
// After reset the position table is cleared entry by entry, with req.ready
// held low; the heap RAM needs no clearing.
// The response sits in an output register: a new request is accepted while
// it waits, but the next response is held back until rsp.ready takes it.
module indexed_max_heap_queue import ihq_pkg::*; #(
	parameter int HEAP_DEPTH   = DEF_HEAP_DEPTH,
	parameter int HANDLE_COUNT = DEF_HANDLE_COUNT,
	parameter int KEY_BITS     = DEF_KEY_BITS
) (
	input  logic clk,
	input  logic arst_n,
	ihq_req_if.sink   req,
	ihq_rsp_if.source rsp
);

	localparam int SW  = $clog2(HEAP_DEPTH + 1);
	localparam int AW  = $clog2(HEAP_DEPTH);
	localparam int HAW = $clog2(HANDLE_COUNT);
	localparam int EW  = KEY_BITS + STAMP_BITS + HANDLE_BITS;

	state_t state_q, state_d;

	logic [HAW-1:0] clr_q;
	logic [SW-1:0]  count_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic out_valid_q;
	logic moved_q;
	rsp_t out_q;

	logic [REQ_BITS-1:0]    req_type_q;
	logic [HANDLE_BITS-1:0] h_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [HANDLE_BITS-1:0] oh_q;
	logic [KEY_BITS-1:0]    ok_q;
	logic [SW-1:0]          i_q;

	// entry being placed
	logic [KEY_BITS-1:0]    x_key_q;
	logic [STAMP_BITS-1:0]  x_stamp_q;
	logic [HANDLE_BITS-1:0] x_h_q;

	// best of entry and left child
	logic [KEY_BITS-1:0]    b_key_q;
	logic [STAMP_BITS-1:0]  b_stamp_q;
	logic [HANDLE_BITS-1:0] b_h_q;
	logic [SW-1:0]          b_slot_q;
	logic b_moved_q;
	logic r_ok_q;

	logic          heap_we;
	logic [AW-1:0] heap_wa, heap_ra;
	logic [EW-1:0] heap_wd, heap_rd;
	logic           pos_we;
	logic [HAW-1:0] pos_wa, pos_ra;
	logic [SW-1:0]  pos_wd, pos_rd;

	logic [KEY_BITS-1:0]    rd_key;
	logic [STAMP_BITS-1:0]  rd_stamp;
	logic [HANDLE_BITS-1:0] rd_h;
	logic [SW:0] l_slot, r_slot, cnt_ext;
	logic l_better, r_better, dn_moved, h_bad, out_load;

	function automatic logic ranks(input logic [KEY_BITS-1:0] ka,
			input logic [STAMP_BITS-1:0] sa, input logic [KEY_BITS-1:0] kb,
			input logic [STAMP_BITS-1:0] sb);
		return (ka != kb) ? (ka > kb) : (sa < sb);
	endfunction

	ihq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
		.clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
		.raddr(heap_ra), .rdata(heap_rd)
	);

	ihq_ram #(.WIDTH(SW), .DEPTH(HANDLE_COUNT)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd),
		.raddr(pos_ra), .rdata(pos_rd)
	);

	assign rd_key   = heap_rd[EW-1 -: KEY_BITS];
	assign rd_stamp = heap_rd[STAMP_BITS+HANDLE_BITS-1 : HANDLE_BITS];
	assign rd_h     = heap_rd[HANDLE_BITS-1:0];

	assign l_slot  = {i_q, 1'b0};
	assign r_slot  = l_slot + (SW+1)'(1);
	assign cnt_ext = {1'b0, count_q};

	assign l_better = ranks(rd_key, rd_stamp, x_key_q, x_stamp_q);
	assign r_better = r_ok_q && ranks(rd_key, rd_stamp, b_key_q, b_stamp_q);
	assign dn_moved = r_better || b_moved_q;
	assign h_bad    = 32'(h_q) >= 32'(HANDLE_COUNT);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		state_d = state_q;
		heap_we = 1'b0;
		heap_wa = AW'(i_q - SW'(1));
		heap_wd = {x_key_q, x_stamp_q, x_h_q};
		heap_ra = '0;
		pos_we  = 1'b0;
		pos_wa  = HAW'(x_h_q);
		pos_wd  = i_q;
		pos_ra  = HAW'(req.data.handle);
		unique case (state_q)
			S_CLEAR: begin
				pos_we = 1'b1;
				pos_wa = clr_q;
				pos_wd = '0;
				if (clr_q == HAW'(HANDLE_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				heap_ra = AW'(count_q - SW'(1));
				state_d = S_DONE;
				case (req_type_q)
					REQ_INSERT: begin
						if (!h_bad && pos_rd == '0 && count_q < SW'(HEAP_DEPTH))
							state_d = S_UP_RD;
					end
					REQ_REMOVE: begin
						if (!h_bad && pos_rd != '0 && pos_rd <= count_q)
							state_d = S_LAST;
					end
					REQ_EXTRACT: begin
						if (count_q != '0) state_d = S_LAST;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_LAST: begin
				pos_we = 1'b1;
				pos_wa = (req_type_q == REQ_REMOVE) ? HAW'(h_q) : HAW'(oh_q);
				pos_wd = '0;
				state_d = (i_q == count_q) ? S_DONE : S_DN_L;
			end
			S_DN_L: begin
				if (l_slot > cnt_ext) begin
					if (moved_q) begin
						heap_we = 1'b1;
						pos_we  = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_UP_RD;
					end
				end else begin
					heap_ra = AW'(l_slot - (SW+1)'(1));
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				heap_ra = AW'(r_slot - (SW+1)'(1));
				state_d = S_DN_C;
			end
			S_DN_C: begin
				if (dn_moved) begin
					heap_we = 1'b1;
					heap_wd = r_better ? heap_rd : {b_key_q, b_stamp_q, b_h_q};
					pos_we  = 1'b1;
					pos_wa  = r_better ? HAW'(rd_h) : HAW'(b_h_q);
					state_d = S_DN_L;
				end else if (moved_q) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_UP_RD: begin
				if (i_q == SW'(1)) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
					state_d = S_DONE;
				end else begin
					heap_ra = AW'((i_q >> 1) - SW'(1));
					state_d = S_UP_C;
				end
			end
			S_UP_C: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (rd_key < x_key_q) begin
					// parent drops into the hole
					heap_wd = heap_rd;
					pos_wa  = HAW'(rd_h);
					state_d = S_UP_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			stamp_q     <= '0;
			out_valid_q <= 1'b0;
			moved_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + HAW'(1);
			if (req.valid && req.ready) moved_q <= 1'b0;
			if (state_q == S_DECODE && req_type_q == REQ_INSERT && !h_bad &&
					pos_rd == '0 && count_q < SW'(HEAP_DEPTH)) begin
				count_q <= count_q + SW'(1);
				stamp_q <= stamp_q + STAMP_BITS'(1);
			end
			if (state_q == S_LAST) count_q <= count_q - SW'(1);
			if (state_q == S_DN_C && dn_moved) moved_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.data.req_type;
			h_q        <= req.data.handle;
			key_q      <= KEY_BITS'(req.data.key);
			status_q   <= STS_OK;
			oh_q       <= '0;
			ok_q       <= '0;
		end
		case (state_q)
			S_DECODE: begin
				case (req_type_q)
					REQ_INSERT: begin
						if (h_bad) status_q <= STS_ABSENT;
						else if (pos_rd != '0) status_q <= STS_DUP;
						else if (count_q >= SW'(HEAP_DEPTH)) status_q <= STS_FULL;
						else begin
							x_key_q   <= key_q;
							x_stamp_q <= stamp_q + STAMP_BITS'(1);
							x_h_q     <= h_q;
							i_q       <= count_q + SW'(1);
						end
					end
					REQ_REMOVE: begin
						if (h_bad || pos_rd == '0 || pos_rd > count_q) status_q <= STS_ABSENT;
						else i_q <= pos_rd;
					end
					REQ_EXTRACT: begin
						if (count_q == '0) status_q <= STS_EMPTY;
						else begin
							oh_q <= rd_h;
							ok_q <= rd_key;
							i_q  <= SW'(1);
						end
					end
					default: ;
				endcase
			end
			S_LAST: begin
				x_key_q   <= rd_key;
				x_stamp_q <= rd_stamp;
				x_h_q     <= rd_h;
			end
			S_DN_R: begin
				b_key_q   <= l_better ? rd_key : x_key_q;
				b_stamp_q <= l_better ? rd_stamp : x_stamp_q;
				b_h_q     <= l_better ? rd_h : x_h_q;
				b_slot_q  <= l_better ? SW'(l_slot) : i_q;
				b_moved_q <= l_better;
				r_ok_q    <= r_slot <= cnt_ext;
			end
			S_DN_C: begin
				if (dn_moved) i_q <= r_better ? SW'(r_slot) : b_slot_q;
			end
			S_UP_C: begin
				if (rd_key < x_key_q) i_q <= i_q >> 1;
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.status     <= status_q;
			out_q.out_handle <= oh_q;
			out_q.out_key    <= KEY_IN_BITS'(ok_q);
			out_q.count      <= COUNT_BITS'(count_q);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SW'(HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !heap_we)
		else $error("heap write outside a request");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		heap_we |-> (i_q != '0 && i_q <= count_q))
		else $error("heap write outside held slots");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req.ready)
		else $error("request taken during clearing pass");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> (rsp.valid && state_q == S_IDLE))
		else $error("finished response not presented");

endmodule
